@@ sv/c6502_pkg.sv @@
`default_nettype none
package c6502_pkg;

  // operation classes produced by the decoder
  typedef enum logic [4:0] {
    OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC,
    OP_RMB, OP_SMB, OP_BBR, OP_BBS,
    OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_INC, OP_DEC,
    OP_BITI, OP_BIT, OP_CPX, OP_CPY, OP_LDX, OP_LDY, OP_STX, OP_STY, OP_STZ,
    OP_TRB, OP_TSB, OP_BRC, OP_JMP
  } op_e;

  typedef enum logic [3:0] {
    MI_NONE, MI_CLC, MI_SEC, MI_CLI, MI_SEI, MI_CLV, MI_CLD, MI_SED,
    MI_TAX, MI_TAY, MI_TXA, MI_TYA, MI_TSX, MI_TXS, MI_INX, MI_INY
  } misc_e;

  typedef struct packed {
    op_e         op;
    misc_e       misc;
    logic        dex;
    logic        dey;
    logic        to_acc;
    logic        bad;
    logic [2:0]  sel;      // bit index or branch condition
    logic [7:0]  value;
    logic [15:0] addr;
  } dec_t;

  localparam int unsigned QDEPTH = 2;

  localparam logic [7:0] FN = 8'h80;
  localparam logic [7:0] FV = 8'h40;
  localparam logic [7:0] FD = 8'h08;
  localparam logic [7:0] FI = 8'h04;
  localparam logic [7:0] FZ = 8'h02;
  localparam logic [7:0] FC = 8'h01;

endpackage
`default_nettype wire

@@ sv/c6502_decode.sv @@
`default_nettype none
module c6502_decode (
  input  wire logic [7:0]  cmd_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [15:0] addr_i,
  output c6502_pkg::dec_t  dec_o
);
  logic [4:0] lo;
  assign lo = cmd_i[4:0];

  always_comb begin
    dec_o        = '0;
    dec_o.op     = c6502_pkg::OP_NOP;
    dec_o.misc   = c6502_pkg::MI_NONE;
    dec_o.value  = value_i;
    dec_o.addr   = addr_i;
    dec_o.sel    = cmd_i[6:4];
    if ((cmd_i[1:0] == 2'b01 || lo == 5'h12) && cmd_i != 8'h89) begin
      unique case (cmd_i[7:5])
        3'd0: dec_o.op = c6502_pkg::OP_ORA;
        3'd1: dec_o.op = c6502_pkg::OP_AND;
        3'd2: dec_o.op = c6502_pkg::OP_EOR;
        3'd3: dec_o.op = c6502_pkg::OP_ADC;
        3'd4: dec_o.op = c6502_pkg::OP_STA;
        3'd5: dec_o.op = c6502_pkg::OP_LDA;
        3'd6: dec_o.op = c6502_pkg::OP_CMP;
        default: dec_o.op = c6502_pkg::OP_SBC;
      endcase
    end else if (cmd_i[3:0] == 4'h7) begin
      dec_o.op = cmd_i[7] ? c6502_pkg::OP_SMB : c6502_pkg::OP_RMB;
    end else if (cmd_i[3:0] == 4'hF) begin
      dec_o.op = cmd_i[7] ? c6502_pkg::OP_BBS : c6502_pkg::OP_BBR;
    end else begin
      unique case (cmd_i)
        8'h0A: begin dec_o.op = c6502_pkg::OP_ASL; dec_o.to_acc = 1'b1; end
        8'h2A: begin dec_o.op = c6502_pkg::OP_ROL; dec_o.to_acc = 1'b1; end
        8'h4A: begin dec_o.op = c6502_pkg::OP_LSR; dec_o.to_acc = 1'b1; end
        8'h6A: begin dec_o.op = c6502_pkg::OP_ROR; dec_o.to_acc = 1'b1; end
        8'h1A: begin dec_o.op = c6502_pkg::OP_INC; dec_o.to_acc = 1'b1; end
        8'h3A: begin dec_o.op = c6502_pkg::OP_DEC; dec_o.to_acc = 1'b1; end
        8'h06, 8'h16, 8'h0E, 8'h1E: dec_o.op = c6502_pkg::OP_ASL;
        8'h26, 8'h36, 8'h2E, 8'h3E: dec_o.op = c6502_pkg::OP_ROL;
        8'h46, 8'h56, 8'h4E, 8'h5E: dec_o.op = c6502_pkg::OP_LSR;
        8'h66, 8'h76, 8'h6E, 8'h7E: dec_o.op = c6502_pkg::OP_ROR;
        8'hE6, 8'hF6, 8'hEE, 8'hFE: dec_o.op = c6502_pkg::OP_INC;
        8'hC6, 8'hD6, 8'hCE, 8'hDE: dec_o.op = c6502_pkg::OP_DEC;
        8'h89: dec_o.op = c6502_pkg::OP_BITI;
        8'h24, 8'h2C, 8'h34, 8'h3C: dec_o.op = c6502_pkg::OP_BIT;
        8'hE0, 8'hE4, 8'hEC: dec_o.op = c6502_pkg::OP_CPX;
        8'hC0, 8'hC4, 8'hCC: dec_o.op = c6502_pkg::OP_CPY;
        8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: dec_o.op = c6502_pkg::OP_LDX;
        8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: dec_o.op = c6502_pkg::OP_LDY;
        8'h86, 8'h96, 8'h8E: dec_o.op = c6502_pkg::OP_STX;
        8'h84, 8'h94, 8'h8C: dec_o.op = c6502_pkg::OP_STY;
        8'h64, 8'h74, 8'h9C, 8'h9E: dec_o.op = c6502_pkg::OP_STZ;
        8'h14, 8'h1C: dec_o.op = c6502_pkg::OP_TRB;
        8'h04, 8'h0C: dec_o.op = c6502_pkg::OP_TSB;
        // conditional branches: sel = {flag pair, polarity}
        8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
          dec_o.op  = c6502_pkg::OP_BRC;
          dec_o.sel = cmd_i[7:5];
        end
        8'h80, 8'h4C, 8'h6C, 8'h7C: dec_o.op = c6502_pkg::OP_JMP;
        8'h18: dec_o.misc = c6502_pkg::MI_CLC;
        8'h38: dec_o.misc = c6502_pkg::MI_SEC;
        8'h58: dec_o.misc = c6502_pkg::MI_CLI;
        8'h78: dec_o.misc = c6502_pkg::MI_SEI;
        8'hB8: dec_o.misc = c6502_pkg::MI_CLV;
        8'hD8: dec_o.misc = c6502_pkg::MI_CLD;
        8'hF8: dec_o.misc = c6502_pkg::MI_SED;
        8'hAA: dec_o.misc = c6502_pkg::MI_TAX;
        8'hA8: dec_o.misc = c6502_pkg::MI_TAY;
        8'h8A: dec_o.misc = c6502_pkg::MI_TXA;
        8'h98: dec_o.misc = c6502_pkg::MI_TYA;
        8'hBA: dec_o.misc = c6502_pkg::MI_TSX;
        8'h9A: dec_o.misc = c6502_pkg::MI_TXS;
        8'hE8: dec_o.misc = c6502_pkg::MI_INX;
        8'hC8: dec_o.misc = c6502_pkg::MI_INY;
        8'hCA: dec_o.dex = 1'b1;
        8'h88: dec_o.dey = 1'b1;
        8'hEA: dec_o.op = c6502_pkg::OP_NOP;
        default: dec_o.bad = 1'b1;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/c6502_queue.sv @@
`default_nettype none
module c6502_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  c6502_pkg::dec_t      push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output c6502_pkg::dec_t      pop_data_o
);
  localparam int unsigned AW = $clog2(c6502_pkg::QDEPTH);

  c6502_pkg::dec_t mem_q [c6502_pkg::QDEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o     = cnt_q == (AW+1)'(c6502_pkg::QDEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("push lost");
endmodule
`default_nettype wire

@@ sv/c6502_exec.sv @@
`default_nettype none
module c6502_exec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        avail_i,
  input  c6502_pkg::dec_t  dec_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [82:0]      out_data_o
);
  logic [7:0] a_q, x_q, y_q, s_q, p_q;
  logic [7:0] a_d, x_d, y_d, s_d, p_d;
  logic       we, pl;
  logic [7:0] wd, r, mv, src;
  logic [8:0] sum;
  logic       cond;
  logic [7:0] bitm;
  logic       vld_q;
  logic [82:0] out_q;

  assign take_o = avail_i && (!vld_q || out_ready_i);

  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; s_d = s_q; p_d = p_q;
    we = 1'b0; pl = 1'b0; wd = '0; r = '0;
    bitm = 8'd1 << dec_i.sel;
    mv = dec_i.op == c6502_pkg::OP_SBC ? ~dec_i.value : dec_i.value;
    sum = {1'b0, a_q} + {1'b0, mv} + {8'd0, p_q[0]};
    src = dec_i.to_acc ? a_q : dec_i.value;
    unique case (dec_i.sel[2:1])
      2'd0: cond = p_q[7];
      2'd1: cond = p_q[6];
      2'd2: cond = p_q[0];
      default: cond = p_q[1];
    endcase
    case (dec_i.op)
      c6502_pkg::OP_ORA, c6502_pkg::OP_AND, c6502_pkg::OP_EOR, c6502_pkg::OP_LDA: begin
        case (dec_i.op)
          c6502_pkg::OP_ORA: r = a_q | dec_i.value;
          c6502_pkg::OP_AND: r = a_q & dec_i.value;
          c6502_pkg::OP_EOR: r = a_q ^ dec_i.value;
          default:           r = dec_i.value;
        endcase
        a_d = r; p_d[1] = r == '0; p_d[7] = r[7];
      end
      c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
        r = sum[7:0];
        a_d = r; p_d[0] = sum[8];
        p_d[6] = (a_q[7] ^ r[7]) & (mv[7] ^ r[7]);
        p_d[1] = r == '0; p_d[7] = r[7];
      end
      c6502_pkg::OP_STA: begin we = 1'b1; wd = a_q; end
      c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
        case (dec_i.op)
          c6502_pkg::OP_CMP: src = a_q;
          c6502_pkg::OP_CPX: src = x_q;
          default:           src = y_q;
        endcase
        r = src - dec_i.value;
        p_d[0] = src >= dec_i.value; p_d[1] = r == '0; p_d[7] = r[7];
      end
      c6502_pkg::OP_RMB: begin we = 1'b1; wd = dec_i.value & ~bitm; end
      c6502_pkg::OP_SMB: begin we = 1'b1; wd = dec_i.value | bitm; end
      c6502_pkg::OP_BBR: pl = !(|(dec_i.value & bitm));
      c6502_pkg::OP_BBS: pl = |(dec_i.value & bitm);
      c6502_pkg::OP_ASL, c6502_pkg::OP_ROL, c6502_pkg::OP_LSR, c6502_pkg::OP_ROR,
      c6502_pkg::OP_INC, c6502_pkg::OP_DEC: begin
        case (dec_i.op)
          c6502_pkg::OP_ASL: begin r = {src[6:0], 1'b0};   p_d[0] = src[7]; end
          c6502_pkg::OP_ROL: begin r = {src[6:0], p_q[0]}; p_d[0] = src[7]; end
          c6502_pkg::OP_LSR: begin r = {1'b0, src[7:1]};   p_d[0] = src[0]; end
          c6502_pkg::OP_ROR: begin r = {p_q[0], src[7:1]}; p_d[0] = src[0]; end
          c6502_pkg::OP_INC: r = src + 8'd1;
          default:           r = src - 8'd1;
        endcase
        p_d[1] = r == '0; p_d[7] = r[7];
        if (dec_i.to_acc) a_d = r;
        else begin we = 1'b1; wd = r; end
      end
      c6502_pkg::OP_BITI: p_d[1] = (a_q & dec_i.value) == '0;
      c6502_pkg::OP_BIT: begin
        p_d[1] = (a_q & dec_i.value) == '0;
        p_d[6] = dec_i.value[6]; p_d[7] = dec_i.value[7];
      end
      c6502_pkg::OP_LDX: begin
        x_d = dec_i.value; p_d[1] = dec_i.value == '0; p_d[7] = dec_i.value[7];
      end
      c6502_pkg::OP_LDY: begin
        y_d = dec_i.value; p_d[1] = dec_i.value == '0; p_d[7] = dec_i.value[7];
      end
      c6502_pkg::OP_STX: begin we = 1'b1; wd = x_q; end
      c6502_pkg::OP_STY: begin we = 1'b1; wd = y_q; end
      c6502_pkg::OP_STZ: we = 1'b1;
      c6502_pkg::OP_TRB: begin
        p_d[1] = (a_q & dec_i.value) == '0; we = 1'b1; wd = dec_i.value & ~a_q;
      end
      c6502_pkg::OP_TSB: begin
        p_d[1] = (a_q & dec_i.value) == '0; we = 1'b1; wd = dec_i.value | a_q;
      end
      c6502_pkg::OP_BRC: pl = cond == dec_i.sel[0];
      c6502_pkg::OP_JMP: pl = 1'b1;
      default: ;
    endcase
    r = '0;
    case (dec_i.misc)
      c6502_pkg::MI_CLC: p_d[0] = 1'b0;
      c6502_pkg::MI_SEC: p_d[0] = 1'b1;
      c6502_pkg::MI_CLI: p_d[2] = 1'b0;
      c6502_pkg::MI_SEI: p_d[2] = 1'b1;
      c6502_pkg::MI_CLV: p_d[6] = 1'b0;
      c6502_pkg::MI_CLD: p_d[3] = 1'b0;
      c6502_pkg::MI_SED: p_d[3] = 1'b1;
      c6502_pkg::MI_TAX: begin x_d = a_q; r = a_q; end
      c6502_pkg::MI_TAY: begin y_d = a_q; r = a_q; end
      c6502_pkg::MI_TXA: begin a_d = x_q; r = x_q; end
      c6502_pkg::MI_TYA: begin a_d = y_q; r = y_q; end
      c6502_pkg::MI_TSX: begin x_d = s_q; r = s_q; end
      c6502_pkg::MI_TXS: s_d = x_q;
      c6502_pkg::MI_INX: begin x_d = x_q + 8'd1; r = x_d; end
      c6502_pkg::MI_INY: begin y_d = y_q + 8'd1; r = y_d; end
      default: ;
    endcase
    if (dec_i.dex) begin x_d = x_q - 8'd1; r = x_d; end
    if (dec_i.dey) begin y_d = y_q - 8'd1; r = y_d; end
    if (dec_i.dex || dec_i.dey ||
        (dec_i.misc >= c6502_pkg::MI_TAX && dec_i.misc != c6502_pkg::MI_TXS)) begin
      p_d[1] = r == '0; p_d[7] = r[7];
    end
    p_d[5] = 1'b0;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= {dec_i.bad, p_d | 8'h20, s_d, y_d, x_d, a_d,
                pl ? dec_i.addr : 16'd0, pl, we ? wd : 8'd0,
                we ? dec_i.addr : 16'd0, we};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; x_q <= '0; y_q <= '0; s_q <= 8'hFF; p_q <= c6502_pkg::FI;
      vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; s_q <= s_d; p_q <= p_d;
      end
      if (take_o) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  a_b_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !p_q[4] && !p_q[5]) else $error("B flag changed");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> vld_q && $stable(out_q)) else $error("result dropped");
  a_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(a_q) && $stable(p_q)) else $error("state moved without item");
endmodule
`default_nettype wire

@@ sv/cmos_6502_instruction_execute.sv @@
// 65C02 execute block: one instruction per request.
// Slave channel s_axis: tdata = {operand_address, operand_value, command}.
// Master channel m_axis: one result per request, tdata lists the write request,
// PC load, A, X, Y, S, status and illegal mark.
// A decoder classifies each request into a two-entry queue; the execute stage
// pops one entry a cycle unless its output register is held, updates A/X/Y/S/P
// and registers the result, which drives m_axis_tvalid.
// Throughput: one request per cycle while m_axis_tready stays high, set by the
// combinational ALU loop through the architectural registers.
// Reset: A=X=Y=0, S=0xFF, only I set; queue and output empty.
// When the receiver stalls, the output register holds, then the queue fills
// and s_axis_tready drops; nothing is lost.
`default_nettype none
module cmos_6502_instruction_execute (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[7:0], operand_value[15:8], operand_address[31:16]
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mem_write_enable[0], mem_write_address[16:1], mem_write_data[24:17],
  // pc_load[25], pc_value[41:26], acc_out[49:42], x_out[57:50], y_out[65:58],
  // sp_out[73:66], status_out[81:74], illegal[82], zero fill to 87
  output logic [87:0]      m_axis_tdata
);
  c6502_pkg::dec_t dec_in, dec_out;
  logic full, empty, take;
  logic [82:0] res;

  c6502_decode u_dec (
    .cmd_i(s_axis_tdata[7:0]), .value_i(s_axis_tdata[15:8]),
    .addr_i(s_axis_tdata[31:16]), .dec_o(dec_in)
  );

  assign s_axis_tready = !full;

  c6502_queue u_q (
    .clk_i, .rst_ni, .push_i(s_axis_tvalid && !full), .push_data_i(dec_in),
    .full_o(full), .pop_i(take), .empty_o(empty), .pop_data_o(dec_out)
  );

  c6502_exec u_ex (
    .clk_i, .rst_ni, .avail_i(!empty), .dec_i(dec_out), .take_o(take),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {5'd0, res};
endmodule
`default_nettype wire

@@ tb/cpu_exec_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module cpu_exec_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [87:0] m_axis_tdata,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);
  localparam logic [7:0] OPC_BITI = 8'h89;
  localparam logic [7:0] OPC_TXA  = 8'h8A;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic        pl;
    logic [15:0] pc;
    logic [7:0]  a, x, y, s, p;
    logic        bad;
  } exec_result_t;

  logic [7:0] reg_a, reg_x, reg_y, reg_s, reg_p;
  exec_result_t expected_results[$];

  function automatic void set_flag(logic [7:0] m, logic on);
    if (on) reg_p = reg_p | m;
    else reg_p = reg_p & ~m;
  endfunction

  function automatic void set_nz(logic [7:0] v);
    set_flag(c6502_pkg::FZ, v == 8'h00);
    set_flag(c6502_pkg::FN, v[7]);
  endfunction

  function automatic void add_with_carry(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, reg_p[0]};
    set_flag(c6502_pkg::FC, sum[8]);
    set_flag(c6502_pkg::FV, ((reg_a ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 8'h00);
    reg_a = sum[7:0];
    set_nz(reg_a);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    set_flag(c6502_pkg::FC, r >= m);
    set_nz(diff);
  endfunction

  // kind: 1 ASL, 2 ROL, 3 LSR, 4 ROR, 5 INC, 6 DEC
  function automatic logic [7:0] shift_or_step(int kind, logic [7:0] v);
    logic [7:0] r;
    logic       cin;
    cin = reg_p[0];
    case (kind)
      1: begin r = {v[6:0], 1'b0}; set_flag(c6502_pkg::FC, v[7]); end
      2: begin r = {v[6:0], cin}; set_flag(c6502_pkg::FC, v[7]); end
      3: begin r = {1'b0, v[7:1]}; set_flag(c6502_pkg::FC, v[0]); end
      4: begin r = {cin, v[7:1]}; set_flag(c6502_pkg::FC, v[0]); end
      5: r = v + 8'd1;
      default: r = v - 8'd1;
    endcase
    set_nz(r);
    return r;
  endfunction

  function automatic exec_result_t execute_instruction(logic [7:0] c, logic [7:0] v,
                                                       logic [15:0] addr);
    exec_result_t res;
    logic         we, pl, bad, to_acc, bset;
    logic [7:0]   wd, bitm;
    int           kind;
    we = 1'b0; pl = 1'b0; bad = 1'b0; to_acc = 1'b0; wd = 8'h00; kind = 0;
    if ((c[1:0] == 2'b01 || c[4:0] == 5'h12) && c != OPC_BITI) begin
      case (c[7:5])
        3'd0: begin reg_a = reg_a | v; set_nz(reg_a); end
        3'd1: begin reg_a = reg_a & v; set_nz(reg_a); end
        3'd2: begin reg_a = reg_a ^ v; set_nz(reg_a); end
        3'd3: add_with_carry(v);
        3'd4: begin we = 1'b1; wd = reg_a; end
        3'd5: begin reg_a = v; set_nz(v); end
        3'd6: compare_reg(reg_a, v);
        default: add_with_carry(~v);
      endcase
    end else if (c[3:0] == 4'h7) begin
      bitm = 8'h01 << c[6:4];
      we = 1'b1;
      wd = c[7] ? (v | bitm) : (v & ~bitm);
    end else if (c[3:0] == 4'hF) begin
      bset = v[c[6:4]];
      pl = c[7] ? bset : !bset;
    end else begin
      case (c)
        8'h0A: begin to_acc = 1'b1; kind = 1; end
        8'h06, 8'h16, 8'h0E, 8'h1E: kind = 1;
        8'h2A: begin to_acc = 1'b1; kind = 2; end
        8'h26, 8'h36, 8'h2E, 8'h3E: kind = 2;
        8'h4A: begin to_acc = 1'b1; kind = 3; end
        8'h46, 8'h56, 8'h4E, 8'h5E: kind = 3;
        8'h6A: begin to_acc = 1'b1; kind = 4; end
        8'h66, 8'h76, 8'h6E, 8'h7E: kind = 4;
        8'h1A: begin to_acc = 1'b1; kind = 5; end
        8'hE6, 8'hF6, 8'hEE, 8'hFE: kind = 5;
        8'h3A: begin to_acc = 1'b1; kind = 6; end
        8'hC6, 8'hD6, 8'hCE, 8'hDE: kind = 6;
        OPC_BITI: set_flag(c6502_pkg::FZ, (reg_a & v) == 8'h00);
        8'h24, 8'h2C, 8'h34, 8'h3C: begin
          set_flag(c6502_pkg::FZ, (reg_a & v) == 8'h00);
          set_flag(c6502_pkg::FV, v[6]);
          set_flag(c6502_pkg::FN, v[7]);
        end
        8'hE0, 8'hE4, 8'hEC: compare_reg(reg_x, v);
        8'hC0, 8'hC4, 8'hCC: compare_reg(reg_y, v);
        8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin reg_x = v; set_nz(v); end
        8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin reg_y = v; set_nz(v); end
        8'h86, 8'h96, 8'h8E: begin we = 1'b1; wd = reg_x; end
        8'h84, 8'h94, 8'h8C: begin we = 1'b1; wd = reg_y; end
        8'h64, 8'h74, 8'h9C, 8'h9E: begin we = 1'b1; wd = 8'h00; end
        8'h14, 8'h1C: begin
          set_flag(c6502_pkg::FZ, (reg_a & v) == 8'h00);
          we = 1'b1; wd = v & ~reg_a;
        end
        8'h04, 8'h0C: begin
          set_flag(c6502_pkg::FZ, (reg_a & v) == 8'h00);
          we = 1'b1; wd = v | reg_a;
        end
        8'h10: pl = !reg_p[7];
        8'h30: pl = reg_p[7];
        8'h50: pl = !reg_p[6];
        8'h70: pl = reg_p[6];
        8'h90: pl = !reg_p[0];
        8'hB0: pl = reg_p[0];
        8'hD0: pl = !reg_p[1];
        8'hF0: pl = reg_p[1];
        8'h80, 8'h4C, 8'h6C, 8'h7C: pl = 1'b1;
        8'h18: set_flag(c6502_pkg::FC, 1'b0);
        8'h38: set_flag(c6502_pkg::FC, 1'b1);
        8'h58: set_flag(c6502_pkg::FI, 1'b0);
        8'h78: set_flag(c6502_pkg::FI, 1'b1);
        8'hB8: set_flag(c6502_pkg::FV, 1'b0);
        8'hD8: set_flag(c6502_pkg::FD, 1'b0);
        8'hF8: set_flag(c6502_pkg::FD, 1'b1);
        8'hAA: begin reg_x = reg_a; set_nz(reg_x); end
        8'hA8: begin reg_y = reg_a; set_nz(reg_y); end
        OPC_TXA: begin reg_a = reg_x; set_nz(reg_a); end
        8'h98: begin reg_a = reg_y; set_nz(reg_a); end
        8'hBA: begin reg_x = reg_s; set_nz(reg_x); end
        8'h9A: reg_s = reg_x;
        8'hE8: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
        8'hC8: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
        8'hCA: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
        8'h88: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
        8'hEA: ;
        default: bad = 1'b1;
      endcase
      if (kind != 0) begin
        if (to_acc) reg_a = shift_or_step(kind, reg_a);
        else begin
          wd = shift_or_step(kind, v);
          we = 1'b1;
        end
      end
    end
    res.we = we;
    res.waddr = we ? addr : 16'h0;
    res.wdata = we ? wd : 8'h0;
    res.pl = pl;
    res.pc = pl ? addr : 16'h0;
    res.a = reg_a;
    res.x = reg_x;
    res.y = reg_y;
    res.s = reg_s;
    res.p = (reg_p & 8'hDF) | 8'h20;
    res.bad = bad;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t want;
    if (!rst_ni) begin
      reg_a = 8'h00; reg_x = 8'h00; reg_y = 8'h00; reg_s = 8'hFF; reg_p = c6502_pkg::FI;
      expected_results.delete();
      errors_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(execute_instruction(s_axis_tdata[7:0],
                                   s_axis_tdata[15:8], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("mem_write_enable", 16'(want.we), 16'(m_axis_tdata[0]));
          check_field("mem_write_address", want.waddr, m_axis_tdata[16:1]);
          check_field("mem_write_data", 16'(want.wdata), 16'(m_axis_tdata[24:17]));
          check_field("pc_load", 16'(want.pl), 16'(m_axis_tdata[25]));
          check_field("pc_value", want.pc, m_axis_tdata[41:26]);
          check_field("acc_out", 16'(want.a), 16'(m_axis_tdata[49:42]));
          check_field("x_out", 16'(want.x), 16'(m_axis_tdata[57:50]));
          check_field("y_out", 16'(want.y), 16'(m_axis_tdata[65:58]));
          check_field("sp_out", 16'(want.s), 16'(m_axis_tdata[73:66]));
          check_field("status_out", 16'(want.p), 16'(m_axis_tdata[81:74]));
          check_field("illegal", 16'(want.bad), 16'(m_axis_tdata[82]));
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  int unsigned errors, pending;
  bit          calm_phase = 0;
  bit          hold_off_req = 0;

  cmos_6502_instruction_execute uut (.*);

  cpu_exec_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("[cmos_6502_instruction_execute] ERROR");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [7:0] c, logic [7:0] v, logic [15:0] a);
    int n;
    if (!calm_phase && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {a, v, c};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    logic [7:0]  dir_ops[] = '{8'hA9, 8'h69, 8'h69, 8'hE9, 8'hC9, 8'hA2, 8'h8A, 8'h2A,
                               8'h6A, 8'h14, 8'h04, 8'h89, 8'h24, 8'h4E, 8'hF7, 8'h0F,
                               8'h8F, 8'hD0, 8'h4C, 8'h02, 8'h48, 8'hDB, 8'hF8, 8'h9A,
                               8'hEA};
    logic [7:0]  dir_val[] = '{8'h7F, 8'h01, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h00,
                               8'h01, 8'hFF, 8'h00, 8'h00, 8'hC0, 8'hFF, 8'h00, 8'h01,
                               8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                               8'h00};
    logic [7:0]  c;
    logic [15:0] a;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_ops[i])
      send_request(dir_ops[i], dir_val[i], (i % 2) ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 1200; i++) begin
      if (i == 300) hold_off_req = 1'b1;
      if (i == 1000) calm_phase = 1'b1;
      c = 8'($urandom_range(0, 255));
      a = 16'($urandom_range(0, 65535));
      send_request(c, 8'($urandom_range(0, 255)), a);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0 || hold_off_req) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("[cmos_6502_instruction_execute] OK");
    else $display("[cmos_6502_instruction_execute] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
